[design/b64d_pkg.sv]
// b64d_pkg: shared types, codes and the character classifier for the base64 decoder
// used by b64d_decode, b64d_outq and base64_stream_decoder_core; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CMP_W      = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
  localparam int BC_W       = 16;

  // pad, space, bad classes above the sextet range; plus, slash, digit base inside it
  localparam logic [7:0] CLS_PAD   = 8'hFE;
  localparam logic [7:0] CLS_SPACE = 8'hFD;
  localparam logic [7:0] CLS_BAD   = 8'hFF;
  localparam logic [7:0] CLS_PLUS  = 8'h3E;
  localparam logic [7:0] CLS_SLASH = 8'h3F;
  localparam logic [7:0] CLS_DIGIT = 8'h34;

  localparam logic [1:0] MODE_LENIENT = 2'd0;
  localparam logic [1:0] MODE_STRICT  = 2'd1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [1:0] REG_URL   = 2'd0;
  localparam logic [1:0] REG_MODE  = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;

  typedef struct packed {
    logic        url_alphabet;
    logic [1:0]  decode_mode;
    logic [15:0] out_limit;
  } cfg_t;

  // results caused by one input character
  typedef struct packed {
    logic [1:0]            nbytes;
    logic [7:0]            byte0;
    logic [7:0]            byte1;
    logic [7:0]            byte2;
    logic [COUNT_BITS-1:0] base_count;
    logic                  has_status;
    logic [1:0]            status;
  } bundle_t;

  function automatic logic [7:0] classify(input logic [7:0] ch, input logic url);
    logic [7:0] c;
    c = CLS_BAD;
    if (ch inside {[8'h41:8'h5A]}) c = 8'(ch - 8'h41);
    else if (ch inside {[8'h61:8'h7A]}) c = 8'(ch - 8'h61 + 8'd26);
    else if (ch inside {[8'h30:8'h39]}) c = 8'(ch - 8'h30 + CLS_DIGIT);
    else if (ch == 8'h3D) c = CLS_PAD;
    else if (ch inside {8'h09, 8'h0A, 8'h0D, 8'h20}) c = CLS_SPACE;
    else if (url && ch == 8'h2D) c = CLS_PLUS;
    else if (url && ch == 8'h5F) c = CLS_SLASH;
    else if (!url && ch == 8'h2B) c = CLS_PLUS;
    else if (!url && ch == 8'h2F) c = CLS_SLASH;
    return c;
  endfunction

endpackage

`default_nettype wire

[design/b64d_decode.sv]
// b64d_decode: per-message decode state and the single-pass step for one character
// depends on b64d_pkg; feeds a result bundle to b64d_outq
`timescale 1ns / 1ps
`default_nettype none

module b64d_decode (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            fire,
  input  wire logic [7:0]      char_in,
  input  wire logic            last_char,
  input  wire b64d_pkg::cfg_t  cfg,
  output b64d_pkg::bundle_t    bundle,
  output logic                 bundle_valid
);

  logic [17:0]                     sextet_acc, sextet_acc_next;
  logic [1:0]                      sextet_count, sextet_count_next;
  logic [2:0]                      pad_count, pad_count_next;
  logic [b64d_pkg::COUNT_BITS-1:0] out_count, out_count_next;
  logic [1:0]                      error_code, error_code_next;

  logic                     skip;
  logic [7:0]               cls;
  logic [5:0]               sx;
  logic [23:0]              word;
  logic [1:0]               nb;
  logic [b64d_pkg::CMP_W-1:0] lim_ext;
  logic [b64d_pkg::CMP_W-1:0] cmax_ext;
  logic [b64d_pkg::CMP_W-1:0] sum3;
  logic [b64d_pkg::CMP_W-1:0] sum_tail;
  logic [3:0]               pad_sum;
  logic                     is_strict;
  logic                     is_lenient;

  assign is_strict  = (cfg.decode_mode == b64d_pkg::MODE_STRICT);
  assign is_lenient = (cfg.decode_mode == b64d_pkg::MODE_LENIENT);
  assign cls        = b64d_pkg::classify(char_in, cfg.url_alphabet);
  assign sx         = cls[5:0];
  assign lim_ext    = b64d_pkg::CMP_W'(cfg.out_limit);
  assign cmax_ext   = b64d_pkg::CMP_W'({b64d_pkg::COUNT_BITS{1'b1}});
  assign sum3       = b64d_pkg::CMP_W'(out_count) + b64d_pkg::CMP_W'(3);
  assign skip       = (error_code != b64d_pkg::ST_OK) ||
                      (char_in == 8'h00 && last_char && !is_strict);

  always_comb begin
    sextet_acc_next   = sextet_acc;
    sextet_count_next = sextet_count;
    pad_count_next    = pad_count;
    out_count_next    = out_count;
    error_code_next   = error_code;
    word              = 24'h0;
    nb                = 2'd0;
    sum_tail          = '0;
    pad_sum           = 4'h0;

    if (!skip) begin
      if (cls == b64d_pkg::CLS_PAD) begin
        if (pad_count != 3'd7) pad_count_next = 3'(pad_count + 3'd1);
      end else if (cls == b64d_pkg::CLS_SPACE) begin
        if (is_strict) error_code_next = b64d_pkg::ST_INVALID;
      end else if (cls == b64d_pkg::CLS_BAD) begin
        if (!is_lenient) error_code_next = b64d_pkg::ST_INVALID;
      end else if (pad_count != 3'd0 && !is_lenient) begin
        error_code_next = b64d_pkg::ST_INVALID;
      end else if (sextet_count == 2'd3) begin
        sextet_acc_next   = 18'h0;
        sextet_count_next = 2'd0;
        if (sum3 <= lim_ext && sum3 <= cmax_ext) begin
          word = {sextet_acc, sx};
          nb   = 2'd3;
        end else begin
          error_code_next = b64d_pkg::ST_OVERFLOW;
        end
      end else begin
        sextet_acc_next   = {sextet_acc[11:0], sx};
        sextet_count_next = 2'(sextet_count + 2'd1);
      end
    end

    // trailing partial group at the end of the message
    if (last_char && error_code_next == b64d_pkg::ST_OK && sextet_count_next != 2'd0) begin
      pad_sum  = 4'(pad_count_next) + 4'(sextet_count_next);
      sum_tail = b64d_pkg::CMP_W'(out_count) +
                 b64d_pkg::CMP_W'(sextet_count_next - 2'd1);
      if (sextet_count_next == 2'd1) begin
        error_code_next = b64d_pkg::ST_INVALID;
      end else if (pad_sum != 4'd4 && is_strict && !cfg.url_alphabet) begin
        error_code_next = b64d_pkg::ST_INVALID;
      end else if (!(sum_tail <= lim_ext && sum_tail <= cmax_ext)) begin
        error_code_next = b64d_pkg::ST_OVERFLOW;
      end else begin
        nb = 2'(sextet_count_next - 2'd1);
        if (sextet_count_next == 2'd2) word = {sextet_acc_next[11:0], 12'h0};
        else word = {sextet_acc_next, 6'h0};
      end
    end

    out_count_next = out_count + b64d_pkg::COUNT_BITS'(nb);

    bundle.nbytes     = nb;
    bundle.byte0      = word[23:16];
    bundle.byte1      = word[15:8];
    bundle.byte2      = word[7:0];
    bundle.base_count = out_count;
    bundle.has_status = last_char;
    bundle.status     = error_code_next;
    bundle_valid      = fire && (last_char || nb != 2'd0);

    if (last_char) begin
      sextet_acc_next   = 18'h0;
      sextet_count_next = 2'd0;
      pad_count_next    = 3'd0;
      out_count_next    = '0;
      error_code_next   = b64d_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sextet_acc   <= 18'h0;
      sextet_count <= 2'd0;
      pad_count    <= 3'd0;
      out_count    <= '0;
      error_code   <= b64d_pkg::ST_OK;
    end else if (fire) begin
      sextet_acc   <= sextet_acc_next;
      sextet_count <= sextet_count_next;
      pad_count    <= pad_count_next;
      out_count    <= out_count_next;
      error_code   <= error_code_next;
    end
  end

endmodule

`default_nettype wire

[design/b64d_outq.sv]
// b64d_outq: two-entry queue of result bundles and the serializer that sends one beat
// per result item; depends on b64d_pkg
`timescale 1ns / 1ps
`default_nettype none

module b64d_outq (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire b64d_pkg::bundle_t  push_data,
  output logic                    has_room,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [31:0]             m_tdata,
  output logic                    m_tlast,
  output logic                    m_tuser
);

  b64d_pkg::bundle_t entry [2];
  logic       head, tail;
  logic [1:0] count;
  logic [1:0] idx;
  logic       pop;
  logic       beat;
  logic       is_byte;
  logic [2:0] items;
  logic [7:0] dbyte;
  logic [1:0] dstatus;
  logic [b64d_pkg::COUNT_BITS-1:0] cnt;
  b64d_pkg::bundle_t hd;

  assign hd       = entry[head];
  assign has_room = (count != 2'd2);
  assign m_tvalid = (count != 2'd0);
  assign beat     = m_tvalid && m_tready;
  assign items    = 3'(hd.nbytes) + 3'(hd.has_status);
  assign is_byte  = (idx < hd.nbytes);
  assign m_tlast  = (3'(idx) + 3'd1 == items);
  assign pop      = beat && m_tlast;

  always_comb begin
    case (idx)
      2'd0:    dbyte = hd.byte0;
      2'd1:    dbyte = hd.byte1;
      2'd2:    dbyte = hd.byte2;
      default: dbyte = 8'h00;
    endcase
    if (!is_byte) dbyte = 8'h00;
    dstatus = is_byte ? b64d_pkg::ST_OK : hd.status;
    cnt = is_byte ? hd.base_count + b64d_pkg::COUNT_BITS'(3'(idx) + 3'd1)
                  : hd.base_count + b64d_pkg::COUNT_BITS'(hd.nbytes);
    m_tuser = !is_byte;
    // data_byte, status, byte_count from bit 0 up
    m_tdata = {6'h0, b64d_pkg::BC_W'(cnt), dstatus, dbyte};
  end

  always_ff @(posedge clk) begin
    if (push) entry[tail] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= 2'd0;
      idx   <= 2'd0;
    end else begin
      if (push) tail <= ~tail;
      if (pop) begin
        head <= ~head;
        idx  <= 2'd0;
      end else if (beat) begin
        idx <= 2'(idx + 2'd1);
      end
      count <= 2'(count + 2'(push) - 2'(pop));
    end
  end

endmodule

`default_nettype wire

[design/base64_stream_decoder_core.sv]
// base64_stream_decoder_core: top level with configuration registers and stream ports
// depends on b64d_pkg, b64d_decode and b64d_outq
//
// Input stream (s_*): one encoded character per beat in s_tdata[7:0], s_tlast on the
// final character of a message. Output stream (m_*): one result item per beat; m_tuser
// is 0 for a data byte and 1 for the end-of-message status item, m_tlast marks the last
// item caused by one character. Each character is decoded in the cycle it is taken and
// its one to four result items are written as a bundle into a two-entry output queue.
// Throughput: one character per cycle while s_tready is high; output runs at one item
// per cycle while m_tready is high, so a group of four characters (three bytes) never
// backs up the input. A character that gives no result leaves the queue untouched.
// s_tready drops only while both queue entries are occupied, so a stalled receiver
// holds the input back after at most two bundles.
// Reset (rst, synchronous) empties the queue, clears the message state and loads the
// registers with standard alphabet, lenient mode and a byte limit of 65535.
// Configuration: APB port, url_alphabet at 0x0, decode_mode at 0x4, out_limit at 0x8.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // char_in
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // data_byte, status, byte_count, zero fill
  output logic             m_tlast,
  output logic             m_tuser,   // is_status
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  b64d_pkg::cfg_t    cfg;
  b64d_pkg::bundle_t bundle;
  logic              bundle_valid;
  logic              has_room;
  logic              fire;
  logic              wr;

  assign pready   = 1'b1;
  assign wr       = psel && penable && pwrite && pready;
  assign s_tready = has_room;
  assign fire     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.url_alphabet <= 1'b0;
      cfg.decode_mode  <= b64d_pkg::MODE_LENIENT;
      cfg.out_limit    <= 16'hFFFF;
    end else if (wr) begin
      case (paddr[3:2])
        b64d_pkg::REG_URL:   cfg.url_alphabet <= pwdata[0];
        b64d_pkg::REG_MODE:  cfg.decode_mode  <= pwdata[1:0];
        b64d_pkg::REG_LIMIT: cfg.out_limit    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      b64d_pkg::REG_URL:   prdata = {31'h0, cfg.url_alphabet};
      b64d_pkg::REG_MODE:  prdata = {30'h0, cfg.decode_mode};
      b64d_pkg::REG_LIMIT: prdata = {16'h0, cfg.out_limit};
      default:             prdata = 32'h0;
    endcase
  end

  b64d_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .char_in      (s_tdata),
    .last_char    (s_tlast),
    .cfg          (cfg),
    .bundle       (bundle),
    .bundle_valid (bundle_valid)
  );

  b64d_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (bundle_valid),
    .push_data (bundle),
    .has_room  (has_room),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

`default_nettype wire

[verif/tb_base64_stream_decoder_core.sv]
// tb_base64_stream_decoder_core: self-checking bench for the base64 stream decoder core,
// predicts every output beat per input character and checks it under random flow control
// depends on b64d_pkg and base64_stream_decoder_core
`timescale 1ns / 1ps

module tb_base64_stream_decoder_core;

  localparam logic [1:0] MODE_RELAXED = 2'd2;
  localparam logic [1:0] MODE_SPARE   = 2'd3;
  localparam logic       ALPHA_STD    = 1'b0;
  localparam logic       ALPHA_URL    = 1'b1;

  typedef struct packed {
    logic        is_status;
    logic [7:0]  data_byte;
    logic [1:0]  status;
    logic [15:0] byte_count;
    logic        end_of_run;
  } dec_item_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // char_in
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // data_byte, status, byte_count, zero fill
  logic        m_tlast;
  logic        m_tuser;           // is_status
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'h0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  // configuration mirror and per-message decoder state
  logic        url_sel;
  logic [1:0]  mode_sel;
  logic [15:0] byte_limit;
  logic [17:0] sextet_buf;
  logic [1:0]  sextet_n;
  logic [2:0]  pads;
  logic [15:0] bytes_out;
  logic [1:0]  msg_err;

  dec_item_t   decoded_q[$];
  dec_item_t   char_results[$];
  dec_item_t   want;
  logic [7:0]  msg_chars[$];

  int err_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int chars_sent = 0;
  int msgs_sent = 0;
  int data_seen = 0;
  int status_seen = 0;

  base64_stream_decoder_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    err_count++;
    if (err_count <= 30)
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, exp_val);
  endtask

  function automatic logic [7:0] char_class(input logic [7:0] ch, input logic url);
    logic [7:0] plus_ch;
    logic [7:0] slash_ch;
    plus_ch  = url ? "-" : "+";
    slash_ch = url ? "_" : "/";
    if (ch >= "A" && ch <= "Z") return ch - "A";
    if (ch >= "a" && ch <= "z") return ch - "a" + 8'd26;
    if (ch >= "0" && ch <= "9") return ch - "0" + b64d_pkg::CLS_DIGIT;
    if (ch == "=") return b64d_pkg::CLS_PAD;
    if (ch == 8'h09 || ch == 8'h0A || ch == 8'h0D || ch == 8'h20) return b64d_pkg::CLS_SPACE;
    if (ch == plus_ch) return b64d_pkg::CLS_PLUS;
    if (ch == slash_ch) return b64d_pkg::CLS_SLASH;
    return b64d_pkg::CLS_BAD;
  endfunction

  function automatic logic [7:0] sextet_char(input logic [5:0] s, input logic url);
    if (s < 26) return "A" + s;
    if (s < 52) return "a" + (s - 26);
    if (s < 62) return "0" + (s - 52);
    if (s == 62) return url ? "-" : "+";
    return url ? "_" : "/";
  endfunction

  function automatic bit room_for(input int n);
    int nxt;
    nxt = bytes_out + n;
    return nxt <= byte_limit && nxt <= 65535;
  endfunction

  function automatic void push_bytes(input logic [23:0] word, input int n);
    dec_item_t it;
    for (int i = 0; i < n; i++) begin
      bytes_out++;
      it = '0;
      it.data_byte = word[23 - 8 * i -: 8];
      it.status = b64d_pkg::ST_OK;
      it.byte_count = bytes_out;
      char_results.push_back(it);
    end
  endfunction

  function automatic void clear_message();
    sextet_buf = '0;
    sextet_n = '0;
    pads = '0;
    bytes_out = '0;
    msg_err = b64d_pkg::ST_OK;
  endfunction

  // expected beats for one accepted character
  function automatic void decode_char(input logic [7:0] ch, input logic last);
    logic [7:0]  cls;
    logic [23:0] word;
    dec_item_t   st;
    char_results.delete();
    if (msg_err == b64d_pkg::ST_OK &&
        !(ch == 8'h00 && last && mode_sel != b64d_pkg::MODE_STRICT)) begin
      cls = char_class(ch, url_sel);
      if (cls == b64d_pkg::CLS_PAD) begin
        if (pads != 3'd7) pads++;
      end else if (cls == b64d_pkg::CLS_SPACE) begin
        if (mode_sel == b64d_pkg::MODE_STRICT) msg_err = b64d_pkg::ST_INVALID;
      end else if (cls == b64d_pkg::CLS_BAD) begin
        if (mode_sel != b64d_pkg::MODE_LENIENT) msg_err = b64d_pkg::ST_INVALID;
      end else if (pads != 0 && mode_sel != b64d_pkg::MODE_LENIENT) begin
        msg_err = b64d_pkg::ST_INVALID;
      end else if (sextet_n == 2'd3) begin
        word = {sextet_buf, cls[5:0]};
        sextet_buf = '0;
        sextet_n = '0;
        if (room_for(3)) push_bytes(word, 3);
        else msg_err = b64d_pkg::ST_OVERFLOW;
      end else begin
        sextet_buf = {sextet_buf[11:0], cls[5:0]};
        sextet_n++;
      end
    end
    if (last) begin
      if (msg_err == b64d_pkg::ST_OK && sextet_n != 0) begin
        if (sextet_n == 2'd1) msg_err = b64d_pkg::ST_INVALID;
        else if (sextet_n + pads != 4 && mode_sel == b64d_pkg::MODE_STRICT &&
                 url_sel == ALPHA_STD)
          msg_err = b64d_pkg::ST_INVALID;
        else if (!room_for(sextet_n - 1)) msg_err = b64d_pkg::ST_OVERFLOW;
        else begin
          word = {6'd0, sextet_buf} << (6 * (4 - sextet_n));
          push_bytes(word, sextet_n - 1);
        end
      end
      st = '0;
      st.is_status = 1'b1;
      st.status = msg_err;
      st.byte_count = bytes_out;
      char_results.push_back(st);
      clear_message();
    end
    if (char_results.size() > 0) char_results[char_results.size() - 1].end_of_run = 1'b1;
    foreach (char_results[i]) decoded_q.push_back(char_results[i]);
  endfunction

  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (m_tuser) status_seen++;
      else data_seen++;
      if (decoded_q.size() == 0) begin
        report_mismatch("beat with nothing pending", m_tdata, 32'h0);
      end else begin
        want = decoded_q.pop_front();
        if (m_tuser !== want.is_status) report_mismatch("is_status", m_tuser, want.is_status);
        if (m_tdata[7:0] !== want.data_byte)
          report_mismatch("data_byte", m_tdata[7:0], want.data_byte);
        if (m_tdata[9:8] !== want.status) report_mismatch("status", m_tdata[9:8], want.status);
        if (m_tdata[25:10] !== want.byte_count)
          report_mismatch("byte_count", m_tdata[25:10], want.byte_count);
        if (m_tlast !== want.end_of_run) report_mismatch("end_of_run", m_tlast, want.end_of_run);
        if (m_tdata[31:26] !== 6'd0) report_mismatch("zero fill", m_tdata[31:26], 32'h0);
      end
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic url, input logic [1:0] mode, input logic [15:0] limit);
    apb_write(b64d_pkg::REG_URL, {31'd0, url});
    apb_write(b64d_pkg::REG_MODE, {30'd0, mode});
    apb_write(b64d_pkg::REG_LIMIT, {16'd0, limit});
    url_sel = url;
    mode_sel = mode;
    byte_limit = limit;
  endtask

  task automatic send_char(input logic [7:0] ch, input logic last);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= ch;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decode_char(ch, last);
    chars_sent++;
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_char(txt[i], i == txt.len() - 1);
    msgs_sent++;
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_chars.size(); i++) send_char(msg_chars[i], i == msg_chars.size() - 1);
    msgs_sent++;
  endtask

  // quiet the input and let every pending beat come out
  task automatic drain();
    s_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_space();
    case ($urandom_range(3))
      0: return 8'h09;
      1: return 8'h0A;
      2: return 8'h0D;
      default: return 8'h20;
    endcase
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(6))
      0, 1: return 8'($urandom_range(255));
      2: return sextet_char(6'($urandom_range(63)), 1'($urandom_range(1)));
      3: return "=";
      4: return pick_space();
      5: return $urandom_range(1) ? "+" : "/";
      default: return $urandom_range(1) ? "-" : "_";
    endcase
  endfunction

  task automatic build_encoded(input int nbytes, input logic url, input bit with_pad,
                               input int ws_pct);
    logic [23:0] grp;
    int take;
    msg_chars.delete();
    for (int k = 0; k < nbytes; k += 3) begin
      take = (nbytes - k >= 3) ? 3 : nbytes - k;
      grp = 24'($urandom);
      for (int j = 0; j <= take; j++) begin
        if ($urandom_range(99) < ws_pct) msg_chars.push_back(pick_space());
        msg_chars.push_back(sextet_char(grp[23 - 6 * j -: 6], url));
      end
      if (take < 3 && with_pad)
        for (int j = take; j < 3; j++) msg_chars.push_back("=");
    end
  endtask

  // mostly well-formed text, some corrupted, shortened or pure noise
  task automatic make_message(input int max_len);
    int kind;
    int len;
    logic url;
    kind = $urandom_range(99);
    len = $urandom_range(max_len, 1);
    url = ($urandom_range(9) == 0) ? !url_sel : url_sel;
    if (kind < 88) begin
      build_encoded(len, url, $urandom_range(1), ($urandom_range(3) == 0) ? 15 : 0);
      if (kind >= 65 && kind < 80)
        msg_chars[$urandom_range(msg_chars.size() - 1)] = noise_char();
      else if (kind >= 80)
        msg_chars.delete($urandom_range(msg_chars.size() - 1));
    end else begin
      msg_chars.delete();
      repeat (len) msg_chars.push_back(noise_char());
    end
    if ($urandom_range(9) == 0) msg_chars.push_back(8'h00);
  endtask

  task automatic test_directed();
    set_config(ALPHA_STD, b64d_pkg::MODE_LENIENT, 16'hFFFF);
    send_text("TWFu");
    send_text("//+/");
    send_text("Q");
    send_text("QQ=");
    send_char(8'hFF, 1'b0);
    send_char(8'h0A, 1'b1);
    msgs_sent++;
    send_char("Q", 1'b0);
    send_char("Q", 1'b0);
    send_char(8'h00, 1'b1);
    msgs_sent++;
    drain();
    set_config(ALPHA_STD, b64d_pkg::MODE_STRICT, 16'hFFFF);
    send_text("QQ==");
    send_char("Q", 1'b0);
    send_char("Q", 1'b0);
    send_char(8'h00, 1'b1);
    msgs_sent++;
  endtask

  task automatic test_random_phase(input logic url, input logic [1:0] mode,
                                   input logic [15:0] limit, input int idle_pct,
                                   input int stall, input int n_chars);
    int start;
    drain();
    set_config(url, mode, limit);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    start = chars_sent;
    while (chars_sent - start < n_chars) begin
      make_message(12);
      send_message();
    end
  endtask

  // receiver holds off long enough for the output queue to fill and block the input
  task automatic test_backpressure();
    drain();
    set_config(ALPHA_URL, MODE_RELAXED, 16'hFFFF);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 150;
    repeat (2) begin
      build_encoded(12, ALPHA_URL, 1'b1, 0);
      send_message();
    end
  endtask

  initial begin
    clear_message();
    url_sel = ALPHA_STD;
    mode_sel = b64d_pkg::MODE_LENIENT;
    byte_limit = 16'hFFFF;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phase(ALPHA_STD, b64d_pkg::MODE_LENIENT, 16'hFFFF, 0, 0, 33);
    test_random_phase(ALPHA_URL, b64d_pkg::MODE_STRICT, 16'hFFFF, 66, 0, 33);
    test_random_phase(ALPHA_STD, b64d_pkg::MODE_STRICT, 16'hFFFF, 0, 66, 33);
    test_random_phase(ALPHA_STD, MODE_RELAXED, 16'd9, 18, 18, 33);
    test_random_phase(ALPHA_URL, MODE_SPARE, 16'd0, 0, 0, 33);
    test_backpressure();
    test_random_phase(ALPHA_URL, MODE_RELAXED, 16'd5, 66, 0, 33);
    test_random_phase(ALPHA_STD, b64d_pkg::MODE_LENIENT, 16'd3, 0, 66, 33);
    test_random_phase(ALPHA_URL, b64d_pkg::MODE_LENIENT, 16'hFFFF, 18, 18, 33);
    drain();
    repeat (10) @(posedge clk);
    $display("covered %0d messages, %0d characters, %0d data beats, %0d status beats",
             msgs_sent, chars_sent, data_seen, status_seen);
    $display("both alphabets, all four decode modes, byte limits 0 to 65535, flow control");
    if (err_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

[filelist.f]
design/b64d_pkg.sv
design/b64d_decode.sv
design/b64d_outq.sv
design/base64_stream_decoder_core.sv
verif/tb_base64_stream_decoder_core.sv
